### hw/rtl/chcc_pkg.sv
// shared types, constants and the contrast curve builder for the color classifier
// no dependencies; imported by every module of the block but the checker
package chcc_pkg;

  // fixed-point widths
  localparam int CordW    = 33;   // cordic x/y, signed Q20
  localparam int AngW     = 27;   // cordic angle, signed Q16 degrees
  localparam int Steps    = 20;   // cordic iterations
  localparam int DivBits  = 7;    // quotient bits of the saturation divider
  localparam int NumW     = 17;   // 100 * diff
  localparam int SumW     = 10;   // r + g + b

  localparam logic [20:0] Sqrt3Q20   = 21'd1816187;
  localparam logic [21:0] IntScale   = 22'd2193120;   // 20 * ceil(2^24 / 153)
  localparam logic signed [AngW-1:0] Deg180 = 27'sd11796480;
  localparam logic signed [AngW-1:0] Deg360 = 27'sd23592960;

  // color window codes
  localparam logic [1:0] OptRed    = 2'd0;
  localparam logic [1:0] OptYellow = 2'd1;
  localparam logic [1:0] OptBlue   = 2'd2;

  typedef logic signed [AngW-1:0] ang_t;
  typedef ang_t atan_tab_t [Steps];

  localparam atan_tab_t AtanQ16 = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
    27'sd117304, 27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334,
    27'sd3667, 27'sd1833, 27'sd917, 27'sd458, 27'sd229,
    27'sd115, 27'sd57, 27'sd29, 27'sd14, 27'sd7
  };

  // per-item side data carried next to the cordic
  typedef struct packed {
    logic       hue_en;
    logic       gray;
    logic [6:0] int_pct;
  } side_t;

  typedef logic [7:0] curve_t [256];

  // shift-subtract quotient, used only while building the curve
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned rem, quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem = rem - b;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid contrast curve, evaluated at elaboration only
  function automatic logic [7:0] curve_point(input int v);
    longint unsigned mag, e, term, acc, y, den, q;
    int d;
    d = 255 - 2 * v;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    e = udiv64(mag * 64'd266623993, 64'd100);
    term = 64'd1 << 28;
    acc = 64'd1 << 28;
    for (int k = 1; k <= 40; k++) begin
      term = udiv64((term * e) >> 28, 64'(k));
      acc = acc + term;
    end
    y = (d > 0) ? acc : udiv64(64'd1 << 56, acc);
    den = (64'd1 << 28) + y;
    q = udiv64(64'd663 * (64'd1 << 28) + den, 64'd2 * den);
    return (q > 64'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic curve_t build_curve();
    curve_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = curve_point(i);
    end
    return t;
  endfunction

endpackage

### hw/rtl/contrast_hsi_color_classifier_core.sv
// top level of the contrast / hsi color classifier: pipeline and window test
// depends on chcc_pkg, chcc_curve, chcc_prep, chcc_cordic, chcc_div
//
// usage
//   input: drive in_red/in_green/in_blue and raise start; an item is taken at
//   every clock edge with start high and busy low. busy stays low, so one
//   pixel can be taken in every cycle.
//   output: out_valid is high for one cycle with out_in_color, out_hue_deg,
//   out_sat_pct and out_int_pct; the receiver must take it in that cycle.
//   pipeline: the curve lookup, prep, the 20-stage cordic and the window test
//   are registered in that order; the cordic sets the depth, the 7-stage
//   divider runs beside it.
//   throughput: one item per cycle, sustained.
//   config: cfg_color_option is written when cfg_valid and cfg_ready are high;
//   cfg_ready is always high. write it only while no item is in flight.
//   reset: synchronous on rst_n low; all valid bits clear, color window goes
//   to red. items in flight are dropped.
//   stall: the receiver cannot hold results off, so the pipeline never stalls.
module contrast_hsi_color_classifier_core import chcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  output logic       out_in_color,
  output logic [8:0] out_hue_deg,
  output logic [6:0] out_sat_pct,
  output logic [6:0] out_int_pct,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_color_option
);

  localparam int SatDly = Steps - DivBits;

  logic                    cv_valid;
  logic [7:0]              cv_red, cv_green, cv_blue;
  logic                    pp_valid;
  logic signed [CordW-1:0] pp_x, pp_y;
  logic                    pp_neg;
  logic [NumW-1:0]         pp_num;
  logic [SumW-1:0]         pp_sum;
  side_t                   pp_side;
  logic                    cd_valid;
  ang_t                    cd_z;
  logic [DivBits-1:0]      dv_quo;

  logic [1:0]              opt_r;
  side_t                   side_r [Steps];
  logic [DivBits-1:0]      sat_r [SatDly];

  logic                    valid_r;
  logic                    hit_r;
  logic [8:0]              hue_r;
  logic [6:0]              sat_pct_r, int_pct_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) opt_r <= OptRed;
    else if (cfg_valid) opt_r <= cfg_color_option;
  end

  chcc_curve u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (cv_valid),
    .out_red   (cv_red),
    .out_green (cv_green),
    .out_blue  (cv_blue)
  );

  chcc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_valid),
    .in_red    (cv_red),
    .in_green  (cv_green),
    .in_blue   (cv_blue),
    .out_valid (pp_valid),
    .out_x     (pp_x),
    .out_y     (pp_y),
    .out_neg   (pp_neg),
    .out_num   (pp_num),
    .out_sum   (pp_sum),
    .out_side  (pp_side)
  );

  chcc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pp_valid),
    .in_x      (pp_x),
    .in_y      (pp_y),
    .in_neg    (pp_neg),
    .out_valid (cd_valid),
    .out_z     (cd_z)
  );

  chcc_div u_div (
    .clk       (clk),
    .in_num    (pp_num),
    .in_den    (pp_sum),
    .out_quo   (dv_quo)
  );

  // side data delay line, aligned with the cordic
  always_ff @(posedge clk) begin
    side_r[0] <= pp_side;
    for (int i = 1; i < Steps; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // quotient delay line, from divider exit to cordic exit
  always_ff @(posedge clk) begin
    sat_r[0] <= dv_quo;
    for (int i = 1; i < SatDly; i++) begin
      sat_r[i] <= sat_r[i-1];
    end
  end

  // hue rounding, masking and window test
  logic [8:0]  hue_nxt, sat_nxt;
  logic        hit_nxt;
  ang_t        tot;
  logic [25:0] tot_b;
  logic [9:0]  hraw;
  side_t       sd;

  always_comb begin
    sd    = side_r[Steps-1];
    tot   = (cd_z < 0) ? (cd_z + Deg360) : cd_z;
    tot_b = 26'(tot) + 26'd32;
    hraw  = tot_b[25:16];
    if (hraw >= 10'd360) hraw = hraw - 10'd360;
    hue_nxt = sd.hue_en ? hraw[8:0] : 9'd0;
    sat_nxt = sd.gray ? 9'd0 : 9'(sat_r[SatDly-1]);
    case (opt_r)
      OptRed: begin
        hit_nxt = (hue_nxt >= 9'd340 || hue_nxt <= 9'd11) &&
                  sat_nxt >= 9'd6 && sat_nxt <= 9'd70 &&
                  sd.int_pct > 7'd15 && sd.int_pct <= 7'd85;
      end
      OptYellow: begin
        hit_nxt = hue_nxt >= 9'd15 && hue_nxt <= 9'd50 &&
                  sat_nxt >= 9'd35 && sd.int_pct > 7'd25 && sd.int_pct <= 7'd100;
      end
      OptBlue: begin
        hit_nxt = hue_nxt >= 9'd100 && hue_nxt <= 9'd230 &&
                  sat_nxt >= 9'd35 && sd.int_pct > 7'd25;
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= cd_valid;
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    hue_r     <= hue_nxt;
    sat_pct_r <= sat_nxt[6:0];
    int_pct_r <= sd.int_pct;
  end

  assign out_valid    = valid_r;
  assign out_in_color = hit_r;
  assign out_hue_deg  = hue_r;
  assign out_sat_pct  = sat_pct_r;
  assign out_int_pct  = int_pct_r;

endmodule

### hw/rtl/chcc_curve.sv
// contrast curve stage: three constant-table lookups, registered
// depends on chcc_pkg
module chcc_curve import chcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam curve_t Curve = build_curve();

  logic       valid_r;
  logic [7:0] red_r, green_r, blue_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
  end

  // lookups
  always_ff @(posedge clk) begin
    red_r   <= Curve[in_red];
    green_r <= Curve[in_green];
    blue_r  <= Curve[in_blue];
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

### hw/rtl/chcc_prep.sv
// preparation stage: min/max, sum, intensity, divider operands, cordic start vector
// depends on chcc_pkg
module chcc_prep import chcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_red,
  input  logic [7:0]             in_green,
  input  logic [7:0]             in_blue,
  output logic                   out_valid,
  output logic signed [CordW-1:0] out_x,
  output logic signed [CordW-1:0] out_y,
  output logic                   out_neg,
  output logic [NumW-1:0]        out_num,
  output logic [SumW-1:0]        out_sum,
  output side_t                  out_side
);

  logic [7:0]              mx, mn;
  logic [SumW-1:0]         sum;
  logic [SumW-1:0]         diff;
  logic [NumW-1:0]         num;
  logic signed [10:0]      xs;
  logic signed [8:0]       gb;
  logic signed [CordW-1:0] xq, yq;
  logic [31:0]             iprod;
  side_t                   side;

  logic                    valid_r;
  logic signed [CordW-1:0] x_r, y_r;
  logic                    neg_r;
  logic [NumW-1:0]         num_r;
  logic [SumW-1:0]         sum_r;
  side_t                   side_r;

  // channel statistics
  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    sum  = SumW'(in_red) + SumW'(in_green) + SumW'(in_blue);
    diff = sum - SumW'(3 * mn);
    num  = NumW'(diff) * NumW'(100);
    iprod = 32'(sum) * 32'(IntScale);
    side.int_pct = iprod[30:24];
    side.gray    = (mx == mn);
    side.hue_en  = (mx != mn) && (num > NumW'(sum));
  end

  // cordic start vector, folded to the right half plane
  always_comb begin
    xs = 11'(2 * int'(in_red)) - 11'(in_green) - 11'(in_blue);
    gb = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    xq = CordW'(xs) <<< 20;
    yq = CordW'(gb) * $signed({1'b0, Sqrt3Q20});
    if (xs < 0) begin
      xq = -xq;
      yq = -yq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    x_r    <= xq;
    y_r    <= yq;
    neg_r  <= (xs < 0);
    num_r  <= num;
    sum_r  <= sum;
    side_r <= side;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_neg   = neg_r;
  assign out_num   = num_r;
  assign out_sum   = sum_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/chcc_cordic.sv
// vectoring cordic, one registered stage per iteration, angle in Q16 degrees
// depends on chcc_pkg
module chcc_cordic import chcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [CordW-1:0] in_x,
  input  logic signed [CordW-1:0] in_y,
  input  logic                    in_neg,
  output logic                    out_valid,
  output ang_t                    out_z
);

  logic                    valid_r [Steps+1];
  logic signed [CordW-1:0] x_r [Steps+1];
  logic signed [CordW-1:0] y_r [Steps+1];
  ang_t                    z_r [Steps+1];

  always_comb begin
    valid_r[0] = in_valid;
    x_r[0]     = in_x;
    y_r[0]     = in_y;
    z_r[0]     = in_neg ? Deg180 : '0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [CordW-1:0] x_nxt, y_nxt;
    ang_t                    z_nxt;

    // one micro-rotation toward the x axis
    always_comb begin
      if (y_r[i] > 0) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + AtanQ16[i];
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - AtanQ16[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) valid_r[i+1] <= 1'b0;
      else valid_r[i+1] <= valid_r[i];
    end

    always_ff @(posedge clk) begin
      x_r[i+1] <= x_nxt;
      y_r[i+1] <= y_nxt;
      z_r[i+1] <= z_nxt;
    end
  end

  assign out_valid = valid_r[Steps];
  assign out_z     = z_r[Steps];

endmodule

### hw/rtl/chcc_div.sv
// restoring divider for saturation, one quotient bit per registered stage
// depends on chcc_pkg
module chcc_div import chcc_pkg::*; (
  input  logic               clk,
  input  logic [NumW-1:0]    in_num,
  input  logic [SumW-1:0]    in_den,
  output logic [DivBits-1:0] out_quo
);

  logic [NumW-1:0]    rem_r [DivBits+1];
  logic [SumW-1:0]    den_r [DivBits+1];
  logic [DivBits-1:0] quo_r [DivBits+1];

  always_comb begin
    rem_r[0]   = in_num;
    den_r[0]   = in_den;
    quo_r[0]   = '0;
  end

  for (genvar s = 0; s < DivBits; s++) begin : g_bit
    localparam int Sh = DivBits - 1 - s;
    logic [NumW-1:0]    dsh;
    logic               take;
    logic [NumW-1:0]    rem_nxt;
    logic [DivBits-1:0] quo_nxt;

    // trial subtract of the shifted divisor
    always_comb begin
      dsh     = NumW'(den_r[s]) << Sh;
      take    = (rem_r[s] >= dsh);
      rem_nxt = take ? (rem_r[s] - dsh) : rem_r[s];
      quo_nxt = quo_r[s];
      quo_nxt[Sh] = take;
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt;
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= quo_nxt;
    end
  end

  assign out_quo   = quo_r[DivBits];

endmodule

### hw/rtl/chcc_checker.sv
// port-level checks for the color classifier top level, with its bind
// depends on contrast_hsi_color_classifier_core
module chcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [8:0] out_hue_deg,
  input logic [6:0] out_sat_pct,
  input logic [6:0] out_int_pct
);

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##23 out_valid)
    else $error("item lost in pipeline");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_deg < 9'd360)
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sat_pct <= 7'd100 && out_int_pct <= 7'd100)
    else $error("percent out of range");

  // zero saturation implies zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat_pct == 7'd0 |-> out_hue_deg == 9'd0)
    else $error("hue set on unsaturated pixel");

endmodule

bind contrast_hsi_color_classifier_core chcc_checker u_chcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_hue_deg (out_hue_deg),
  .out_sat_pct (out_sat_pct),
  .out_int_pct (out_int_pct)
);

### tb/tb_top.sv
// self-checking bench for contrast_hsi_color_classifier_core: random and directed pixels
// depends on chcc_pkg (window codes) and the core; predicts each pixel's classification
module tb_top;
  import chcc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_red, in_green, in_blue;
  logic       out_valid, out_in_color;
  logic [8:0] out_hue_deg;
  logic [6:0] out_sat_pct, out_int_pct;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_color_option;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    logic       hit;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] inten;
  } class_t;

  pixel_t pixel_q [$];
  class_t class_q [$];
  logic [7:0] curve_lut [256];
  logic [1:0] window_sel;
  int  mismatches;
  int  gap_left;
  bit  gaps_on;
  bit  hold_feed;
  bit  timed_out;
  int  quiet_cycles;

  contrast_hsi_color_classifier_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_in_color(out_in_color), .out_hue_deg(out_hue_deg),
    .out_sat_pct(out_sat_pct), .out_int_pct(out_int_pct),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_color_option(cfg_color_option)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sigmoid contrast value of one channel, q28 taylor exp
  function automatic logic [7:0] stretch(input int v);
    longint unsigned mag, e, term, acc, y, den, q;
    int d;
    d = 255 - 2 * v;
    mag = (d < 0) ? -d : d;
    e = mag * 64'd266623993 / 64'd100;
    term = 64'd1 << 28;
    acc = 64'd1 << 28;
    for (int k = 1; k <= 40; k++) begin
      term = ((term * e) >> 28) / k;
      acc += term;
    end
    y = (d > 0) ? acc : ((64'd1 << 56) / acc);
    den = (64'd1 << 28) + y;
    q = (64'd663 * (64'd1 << 28) + den) / (64'd2 * den);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic longint fshr(input longint v, input int n);
    if (v >= 0) return v >>> n;
    return -((-(v + 1)) >>> n) - 1;
  endfunction

  // vectoring cordic hue in whole degrees
  function automatic int hue_angle(input int r, input int g, input int b);
    longint x, y, z, dx, dy, t;
    longint atan_q [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    int h;
    x = longint'(2 * r - g - b) * (64'sd1 << 20);
    y = longint'(g - b) * 1816187;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 180 * 65536;
    end
    for (int i = 0; i < 20; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q[i];
      end else begin
        x -= dx; y += dy; z -= atan_q[i];
      end
    end
    t = z;
    if (t < 0) t += 360 * 65536;
    h = int'((t + 32) >>> 16);
    if (h >= 360) h -= 360;
    return h;
  endfunction

  function automatic class_t classify(input pixel_t p, input logic [1:0] sel);
    class_t c;
    int r, g, b, mx, mn, sum, hue, sat, inten, diff;
    bit hit;
    r = curve_lut[p.r];
    g = curve_lut[p.g];
    b = curve_lut[p.b];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = r + g + b;
    hue = 0; sat = 0;
    inten = 20 * sum / 153;
    // gray and near-gray pixels keep hue at zero
    if (mx != mn) begin
      diff = sum - 3 * mn;
      sat = 100 * diff / sum;
      if (100 * diff > sum) hue = hue_angle(r, g, b);
    end
    hit = 1'b0;
    case (sel)
      OptRed:    hit = (hue >= 340 || hue <= 11) && sat >= 6 && sat <= 70 &&
                       inten > 15 && inten <= 85;
      OptYellow: hit = hue >= 15 && hue <= 50 && sat >= 35 && inten > 25;
      OptBlue:   hit = hue >= 100 && hue <= 230 && sat >= 35 && inten > 25;
      default:   hit = 1'b0;
    endcase
    c.hit = hit;
    c.hue = hue[8:0];
    c.sat = sat[6:0];
    c.inten = inten[6:0];
    return c;
  endfunction

  // driver: one item per handshake, with random gap bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        class_q.insert(class_q.size(), classify({in_red, in_green, in_blue}, window_sel));
        void'(pixel_q.pop_front());
      end
      if (start && busy) begin
        // hold the current item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 6);
        start <= 1'b0;
      end else if (!hold_feed && pixel_q.size() > 0) begin
        start <= 1'b1;
        {in_red, in_green, in_blue} <= pixel_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (class_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hue %0d", out_hue_deg);
      end else begin
        class_t e;
        e = class_q.pop_front();
        if ({out_in_color, out_hue_deg, out_sat_pct, out_int_pct} !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %0d hue %0d sat %0d int %0d, got %0d %0d %0d %0d",
                     e.hit, e.hue, e.sat, e.inten,
                     out_in_color, out_hue_deg, out_sat_pct, out_int_pct);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) timed_out <= 1'b1;
  end

  task automatic drain();
    while (pixel_q.size() != 0 || start) @(posedge clk);
    while (class_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_window(input logic [1:0] sel);
    cfg_valid <= 1'b1;
    cfg_color_option <= sel;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_sel = sel;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t p;
    p.r = r; p.g = g; p.b = b;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  // random pixels leaning toward each color window, plus near-gray and fully random ones
  task automatic add_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 5);
      case (k)
        0: add_pixel(8'($urandom_range(150, 255)), 8'($urandom_range(0, 140)),
                     8'($urandom_range(0, 140)));
        1: add_pixel(8'($urandom_range(150, 255)), 8'($urandom_range(130, 255)),
                     8'($urandom_range(0, 110)));
        2: add_pixel(8'($urandom_range(0, 120)), 8'($urandom_range(0, 200)),
                     8'($urandom_range(140, 255)));
        3: begin
          k = $urandom_range(0, 255);
          add_pixel(8'(k), 8'(k + int'($urandom_range(0, 3))), 8'(k));
        end
        default: add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    timed_out = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    hold_feed = 1'b0;
    window_sel = OptRed;
    rst_n = 1'b0;
    start = 1'b0;
    in_red = '0; in_green = '0; in_blue = '0;
    cfg_valid = 1'b0;
    cfg_color_option = OptRed;
    for (int i = 0; i < 256; i++) curve_lut[i] = stretch(i);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        // directed: black, white, primaries, secondaries, gray, near-gray, channel extremes
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(128, 128, 128);
        add_pixel(127, 128, 127);
        add_pixel(200, 201, 200);
        add_pixel(255, 254, 254);
        add_pixel(200, 80, 90);
        add_pixel(230, 60, 70);
        add_pixel(240, 200, 40);
        add_pixel(40, 90, 220);
        add_pixel(255, 0, 1);
        add_pixel(1, 0, 255);
        add_pixel(170, 85, 85);
        add_pixel(85, 170, 170);
        drain();
        write_window(OptYellow);
        add_random(120);
        drain();
        write_window(OptBlue);
        // pause until every result is in, then resume
        add_random(60);
        while (pixel_q.size() != 0) @(posedge clk);
        hold_feed = 1'b1;
        while (class_q.size() != 0 && !timed_out) @(posedge clk);
        hold_feed = 1'b0;
        add_random(60);
        drain();
        write_window(2'd3);
        add_random(60);
        drain();
        write_window(OptRed);
        add_random(120);
        drain();
        write_window(OptBlue);
        gaps_on = 1'b0;
        add_random(80);
        drain();
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
      end
      begin
        wait (timed_out);
        $display("*** FAILED ***");
        $finish;
      end
    join
  end

endmodule
